### rtl/bba_pkg.sv
// Shared types, constants and tree-layout helpers for the buddy block allocator.
package bba_pkg;

    localparam int TOP_ORDER       = 10;
    localparam int MIN_BLOCK_BYTES = 16;
    localparam int HEADER_BYTES    = 16;

    localparam int UNIT_W     = TOP_ORDER;
    localparam int UNIT_COUNT = 1 << TOP_ORDER;
    localparam int ORD_W      = $clog2(TOP_ORDER + 2);
    localparam int ADDR_LSB   = $clog2(MIN_BLOCK_BYTES);
    localparam int SIZE_W     = 25;
    localparam int NEED_W     = SIZE_W + 1;

    // Free-map rows: each order packs its tree nodes into 32-bit rows.
    localparam int ROW_BITS  = 32;
    localparam int ROW_SHIFT = $clog2(ROW_BITS);

    function automatic int rows_of(int j);
        int bits;
        bits = 1 << (TOP_ORDER - j);
        return (bits + ROW_BITS - 1) / ROW_BITS;
    endfunction

    function automatic int row_base(int k);
        int b;
        b = 0;
        for (int j = 0; j <= TOP_ORDER; j++) begin
            if (j < k) begin
                b = b + rows_of(j);
            end
        end
        return b;
    endfunction

    function automatic int row_order(int r);
        int o;
        o = 0;
        for (int j = 0; j <= TOP_ORDER; j++) begin
            if (r >= row_base(j)) begin
                o = j;
            end
        end
        return o;
    endfunction

    localparam int FM_ROWS  = row_base(TOP_ORDER + 1);
    localparam int FM_ROW_W = $clog2(FM_ROWS);
    localparam int TOP_ROW  = FM_ROWS - 1;

    localparam int AM_ROWS  = UNIT_COUNT / ROW_BITS;
    localparam int AM_ROW_W = $clog2(AM_ROWS);

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_BLOCK = 2'd1,
        STAT_BAD_FREE = 2'd2
    } status_t;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_PICK,
        OP_TAKE,
        OP_SPLIT_RD,
        OP_SET_WR,
        OP_AM_RD,
        OP_AM_SET,
        OP_MARK_CLR,
        OP_BUDDY_RD,
        OP_BUDDY_CLR,
        OP_HOME_RD,
        OP_FAIL_NOBLK,
        OP_FAIL_BAD,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic is_free;
        logic alloc_fail;
        logic bad_addr;
        logic mark_set;
        logic k_gt_want;
        logic k_lt_top;
        logic mate_free;
        logic out_free;
    } dp_sts_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_TAKE,
        ST_SPLIT,
        ST_SPLIT_WR,
        ST_ASET,
        ST_MCHK,
        ST_BUDDY,
        ST_BCHK,
        ST_HOME_WR,
        ST_DONE
    } ctl_state_t;

endpackage

### rtl/bba_ram.sv
// Generic simple dual-port RAM with registered read.
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/bba_datapath.sv
// Datapath: free-map rows, allocation marks, block orders, address math and result register.
module bba_datapath import bba_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  dp_cmd_t           cmd,
    output dp_sts_t           sts,
    input  logic              s_req_type,
    input  logic [SIZE_W-1:0] s_req_size,
    input  logic [63:0]       s_free_address,
    input  logic              cfg_we,
    input  logic [63:0]       cfg_data,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_status,
    output logic [63:0]       m_blk_addr,
    output logic [4:0]        m_block_order
);

    logic                type_reg, type_next;
    logic [ORD_W-1:0]    want_reg, want_next;
    logic                too_big_reg, too_big_next;
    logic                bad_addr_reg, bad_addr_next;
    logic [ORD_W-1:0]    k_reg, k_next;
    logic [ORD_W-1:0]    first_reg, first_next;
    logic [UNIT_W-1:0]   u_reg, u_next;
    logic [FM_ROW_W-1:0] row_reg, row_next;
    logic [ROW_SHIFT-1:0] bit_reg, bit_next;
    status_t             code_reg, code_next;
    logic [63:0]         heap_base_reg, hdr_base_reg;
    logic [FM_ROWS-1:0]  fm_ne_reg, fm_vld_reg;
    logic [AM_ROWS-1:0]  am_vld_reg;
    logic                rd_vld_reg, rd_top_reg, am_rd_vld_reg;
    logic                m_valid_reg, m_valid_next;
    status_t             m_status_reg;
    logic [63:0]         m_addr_reg;
    logic [4:0]          m_order_reg;

    // memory ports
    logic                fm_rd_en, fm_we;
    logic [FM_ROW_W-1:0] fm_rd_addr;
    logic [ROW_BITS-1:0] fm_rd_data, fm_wdata, fm_word;
    logic                am_rd_en, am_we;
    logic [AM_ROW_W-1:0] am_rd_addr, am_wr_addr;
    logic [ROW_BITS-1:0] am_rd_data, am_wdata, am_word;
    logic                ao_we;
    logic [ORD_W-1:0]    ao_rd_data, ao_clip;

    // request decode
    logic [NEED_W-1:0]   need;
    logic [ORD_W-1:0]    want_cnt;
    logic [63:0]         off;
    logic                off_bad;

    // search
    logic [TOP_ORDER:0]  order_ne;
    logic [ORD_W-1:0]    k_found;
    logic                found;
    logic [FM_ROW_W-1:0] row_found;
    logic [ROW_SHIFT-1:0] low_bit;
    logic [ORD_W-1:0]    sel_k;
    logic [UNIT_W-1:0]   sel_idx;
    logic [FM_ROW_W-1:0] sel_row;
    logic [ROW_BITS-1:0] bit_mask;
    logic [UNIT_W-1:0]   take_idx;

    bba_ram #(.WIDTH(ROW_BITS), .DEPTH(FM_ROWS)) u_fm_ram (
        .aclk    (aclk),
        .wr_en   (fm_we),
        .wr_addr (row_reg),
        .wr_data (fm_wdata),
        .rd_en   (fm_rd_en),
        .rd_addr (fm_rd_addr),
        .rd_data (fm_rd_data)
    );

    bba_ram #(.WIDTH(ROW_BITS), .DEPTH(AM_ROWS)) u_am_ram (
        .aclk    (aclk),
        .wr_en   (am_we),
        .wr_addr (am_wr_addr),
        .wr_data (am_wdata),
        .rd_en   (am_rd_en),
        .rd_addr (am_rd_addr),
        .rd_data (am_rd_data)
    );

    bba_ram #(.WIDTH(ORD_W), .DEPTH(UNIT_COUNT)) u_ao_ram (
        .aclk    (aclk),
        .wr_en   (ao_we),
        .wr_addr (u_reg),
        .wr_data (want_reg),
        .rd_en   (am_rd_en),
        .rd_addr (u_reg),
        .rd_data (ao_rd_data)
    );

    // rows never written read as their reset contents
    assign fm_word = rd_vld_reg ? fm_rd_data : (rd_top_reg ? ROW_BITS'(1) : '0);
    assign am_word = am_rd_vld_reg ? am_rd_data : '0;
    assign ao_clip = (ao_rd_data > ORD_W'(TOP_ORDER)) ? ORD_W'(TOP_ORDER) : ao_rd_data;

    always_comb begin
        need     = NEED_W'(s_req_size) + NEED_W'(HEADER_BYTES);
        want_cnt = '0;
        for (int kk = 0; kk <= TOP_ORDER; kk++) begin
            if ((NEED_W'(MIN_BLOCK_BYTES) << kk) < need) begin
                want_cnt = want_cnt + ORD_W'(1);
            end
        end
        off     = s_free_address - hdr_base_reg;
        off_bad = (off[ADDR_LSB-1:0] != '0) || (off[63:UNIT_W+ADDR_LSB] != '0);
    end

    always_comb begin
        order_ne = '0;
        for (int r = 0; r < FM_ROWS; r++) begin
            order_ne[row_order(r)] = order_ne[row_order(r)] | fm_ne_reg[r];
        end
        k_found = '0;
        found   = 1'b0;
        for (int kk = TOP_ORDER; kk >= 0; kk--) begin
            if (order_ne[kk] && (ORD_W'(kk) >= want_reg)) begin
                k_found = ORD_W'(kk);
                found   = 1'b1;
            end
        end
        row_found = '0;
        for (int r = FM_ROWS - 1; r >= 0; r--) begin
            if (fm_ne_reg[r] && (ORD_W'(row_order(r)) == k_found)) begin
                row_found = FM_ROW_W'(r);
            end
        end
        low_bit = '0;
        for (int b = ROW_BITS - 1; b >= 0; b--) begin
            if (fm_word[b]) begin
                low_bit = ROW_SHIFT'(b);
            end
        end
    end

    // node select for the read ops
    always_comb begin
        sel_k   = k_reg;
        sel_idx = u_reg >> k_reg;
        unique case (cmd.op)
            OP_SPLIT_RD: begin
                sel_k   = k_reg - ORD_W'(1);
                sel_idx = (u_reg >> sel_k) | UNIT_W'(1);
            end
            OP_BUDDY_RD: sel_idx = (u_reg >> k_reg) ^ UNIT_W'(1);
            default:     sel_idx = u_reg >> k_reg;
        endcase
        sel_row  = FM_ROW_W'(row_base(int'(sel_k))) + FM_ROW_W'(sel_idx >> ROW_SHIFT);
        bit_mask = ROW_BITS'(1) << bit_reg;
        take_idx = (UNIT_W'(row_reg - FM_ROW_W'(row_base(int'(k_reg)))) << ROW_SHIFT)
                 | UNIT_W'(low_bit);
    end

    always_comb begin
        type_next     = type_reg;
        want_next     = want_reg;
        too_big_next  = too_big_reg;
        bad_addr_next = bad_addr_reg;
        k_next        = k_reg;
        first_next    = first_reg;
        u_next        = u_reg;
        row_next      = row_reg;
        bit_next      = bit_reg;
        code_next     = code_reg;
        fm_rd_en      = 1'b0;
        fm_rd_addr    = sel_row;
        fm_we         = 1'b0;
        fm_wdata      = fm_word;
        am_rd_en      = 1'b0;
        am_rd_addr    = AM_ROW_W'(u_reg >> ROW_SHIFT);
        am_wr_addr    = AM_ROW_W'(u_reg >> ROW_SHIFT);
        am_we         = 1'b0;
        am_wdata      = am_word;
        ao_we         = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;

        unique case (cmd.op)
            OP_LOAD: begin
                type_next     = s_req_type;
                want_next     = want_cnt;
                too_big_next  = (want_cnt > ORD_W'(TOP_ORDER));
                bad_addr_next = off_bad;
                u_next        = off[UNIT_W+ADDR_LSB-1:ADDR_LSB];
                code_next     = STAT_OK;
            end
            OP_PICK: begin
                k_next     = k_found;
                row_next   = row_found;
                fm_rd_en   = 1'b1;
                fm_rd_addr = row_found;
            end
            OP_TAKE: begin
                u_next   = take_idx << k_reg;
                fm_we    = 1'b1;
                fm_wdata = fm_word & ~(ROW_BITS'(1) << low_bit);
            end
            OP_SPLIT_RD, OP_BUDDY_RD, OP_HOME_RD: begin
                k_next   = sel_k;
                row_next = sel_row;
                bit_next = sel_idx[ROW_SHIFT-1:0];
                fm_rd_en = 1'b1;
            end
            OP_SET_WR: begin
                fm_we    = 1'b1;
                fm_wdata = fm_word | bit_mask;
            end
            OP_AM_RD: am_rd_en = 1'b1;
            OP_AM_SET: begin
                am_we    = 1'b1;
                am_wdata = am_word | (ROW_BITS'(1) << u_reg[ROW_SHIFT-1:0]);
                ao_we    = 1'b1;
            end
            OP_MARK_CLR: begin
                am_we      = 1'b1;
                am_wdata   = am_word & ~(ROW_BITS'(1) << u_reg[ROW_SHIFT-1:0]);
                k_next     = ao_clip;
                first_next = ao_clip;
            end
            OP_BUDDY_CLR: begin
                fm_we    = 1'b1;
                fm_wdata = fm_word & ~bit_mask;
                u_next   = u_reg & ~(UNIT_W'(1) << k_reg);
                k_next   = k_reg + ORD_W'(1);
            end
            OP_FAIL_NOBLK: code_next = STAT_NO_BLOCK;
            OP_FAIL_BAD:   code_next = STAT_BAD_FREE;
            OP_OUT:        m_valid_next = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fm_ne_reg     <= FM_ROWS'(1) << TOP_ROW;
            fm_vld_reg    <= '0;
            am_vld_reg    <= '0;
            m_valid_reg   <= 1'b0;
            heap_base_reg <= '0;
            hdr_base_reg  <= 64'(HEADER_BYTES);
        end else begin
            m_valid_reg <= m_valid_next;
            if (fm_we) begin
                fm_ne_reg[row_reg]  <= |fm_wdata;
                fm_vld_reg[row_reg] <= 1'b1;
            end
            if (am_we) begin
                am_vld_reg[am_wr_addr] <= 1'b1;
            end
            if (cfg_we) begin
                heap_base_reg <= cfg_data;
                hdr_base_reg  <= cfg_data + 64'(HEADER_BYTES);
            end
        end
    end

    always_ff @(posedge aclk) begin
        type_reg     <= type_next;
        want_reg     <= want_next;
        too_big_reg  <= too_big_next;
        bad_addr_reg <= bad_addr_next;
        k_reg        <= k_next;
        first_reg    <= first_next;
        u_reg        <= u_next;
        row_reg      <= row_next;
        bit_reg      <= bit_next;
        code_reg     <= code_next;
        if (fm_rd_en) begin
            rd_vld_reg <= fm_vld_reg[fm_rd_addr];
            rd_top_reg <= (fm_rd_addr == FM_ROW_W'(TOP_ROW));
        end
        if (am_rd_en) begin
            am_rd_vld_reg <= am_vld_reg[am_rd_addr];
        end
        if (cmd.op == OP_OUT) begin
            m_status_reg <= code_reg;
            m_addr_reg   <= (code_reg == STAT_OK && type_reg == REQ_ALLOC)
                          ? heap_base_reg + 64'({u_reg, {ADDR_LSB{1'b0}}}) + 64'(HEADER_BYTES)
                          : '0;
            m_order_reg  <= (code_reg != STAT_OK) ? 5'd0
                          : (type_reg == REQ_ALLOC) ? 5'(want_reg) : 5'(first_reg);
        end
    end

    assign sts.is_free    = (type_reg == REQ_FREE);
    assign sts.alloc_fail = too_big_reg || !found;
    assign sts.bad_addr   = bad_addr_reg;
    assign sts.mark_set   = am_word[u_reg[ROW_SHIFT-1:0]];
    assign sts.k_gt_want  = (k_reg > want_reg);
    assign sts.k_lt_top   = (k_reg < ORD_W'(TOP_ORDER));
    assign sts.mate_free  = fm_word[bit_reg];
    assign sts.out_free   = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_blk_addr    = m_addr_reg;
    assign m_block_order = m_order_reg;

endmodule

### rtl/bba_ctrl.sv
// Controller: sequences search, split, mark and coalesce steps for one request.
module bba_ctrl import bba_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    ctl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_valid) state_next = ST_DECIDE;
            ST_DECIDE: begin
                if (sts.is_free) begin
                    state_next = sts.bad_addr ? ST_DONE : ST_MCHK;
                end else begin
                    state_next = sts.alloc_fail ? ST_DONE : ST_TAKE;
                end
            end
            ST_TAKE:     state_next = ST_SPLIT;
            ST_SPLIT:    state_next = sts.k_gt_want ? ST_SPLIT_WR : ST_ASET;
            ST_SPLIT_WR: state_next = ST_SPLIT;
            ST_ASET:     state_next = ST_DONE;
            ST_MCHK:     state_next = sts.mark_set ? ST_BUDDY : ST_DONE;
            ST_BUDDY:    state_next = sts.k_lt_top ? ST_BCHK : ST_HOME_WR;
            ST_BCHK:     state_next = sts.mate_free ? ST_BUDDY : ST_HOME_WR;
            ST_HOME_WR:  state_next = ST_DONE;
            ST_DONE:     if (sts.out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.op  = OP_NOP;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) cmd.op = OP_LOAD;
            end
            ST_DECIDE: begin
                if (sts.is_free) begin
                    cmd.op = sts.bad_addr ? OP_FAIL_BAD : OP_AM_RD;
                end else begin
                    cmd.op = sts.alloc_fail ? OP_FAIL_NOBLK : OP_PICK;
                end
            end
            ST_TAKE:     cmd.op = OP_TAKE;
            // walk down, freeing each upper half
            ST_SPLIT:    cmd.op = sts.k_gt_want ? OP_SPLIT_RD : OP_AM_RD;
            ST_SPLIT_WR: cmd.op = OP_SET_WR;
            ST_ASET:     cmd.op = OP_AM_SET;
            ST_MCHK:     cmd.op = sts.mark_set ? OP_MARK_CLR : OP_FAIL_BAD;
            ST_BUDDY:    cmd.op = sts.k_lt_top ? OP_BUDDY_RD : OP_HOME_RD;
            // merge while the buddy is free, else drop the merged block in place
            ST_BCHK:     cmd.op = sts.mate_free ? OP_BUDDY_CLR : OP_HOME_RD;
            ST_HOME_WR:  cmd.op = OP_SET_WR;
            ST_DONE:     if (sts.out_free) cmd.op = OP_OUT;
            default:     cmd.op = OP_NOP;
        endcase
    end

endmodule

### rtl/buddy_block_allocator.sv
// Top level of the buddy block allocator: controller, datapath and checks.
//
//  channel  direction  handshake           payload
//  s_       in         s_valid / s_ready   s_req_type, s_req_size, s_free_address
//  m_       out        m_valid / m_ready   m_status, m_blk_addr, m_block_order
//  cfg_     in         cfg_valid/cfg_ready cfg_data (heap_base)
//
// One request at a time. An allocate splits S times, S from 0 to 10; a free merges M times,
// M from 0 to 10. A too-large allocate, a malformed free address or a free of a block
// that is not allocated ends early with a failure status.
// Each split or merge level costs a read and a write of the free-map row memory.
// Synchronous active-low reset; no clearing pass, row valid bits stand in for reset contents.
// A finished result waits in the output register; the next request is taken meanwhile,
// and its own result holds in the last state until the register is free.
module buddy_block_allocator import bba_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [24:0] s_req_size,
    input  logic [63:0] s_free_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [63:0] m_blk_addr,
    output logic [4:0]  m_block_order,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    bba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bba_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_req_type      (s_req_type),
        .s_req_size      (s_req_size),
        .s_free_address  (s_free_address),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_data        (cfg_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_blk_addr      (m_blk_addr),
        .m_block_order   (m_block_order)
    );

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while another is in flight");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != 2'(STAT_OK)) |-> (m_blk_addr == '0) && (m_block_order == '0))
        else $error("failed request carries address or order");

    a_order_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_block_order <= 5'(TOP_ORDER)))
        else $error("block order beyond heap");

    a_free_no_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == 2'(STAT_BAD_FREE)) |-> (m_blk_addr == '0))
        else $error("bad free returns an address");

endmodule
